>>> hw/rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int DEF_ROWS    = 20;
    localparam int DEF_COLUMNS = 80;

    localparam int CHAR_W      = 8;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;

    localparam logic [CHAR_W-1:0] CODE_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CODE_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_CR  = 8'd13;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [CHAR_W-1:0]      char_code;
        logic [ROW_FIELD_W-1:0] read_row;
        logic [COL_FIELD_W-1:0] read_col;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0]      cell_char;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_col;
    } rsp_t;

endpackage

>>> hw/rtl/tcce_ram.sv
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Character-cell console with cursor, wrap, CR/LF and scroll-up. Screen bytes
// live in a RAM addressed through a top-row ring pointer; a per-row fill
// RAM and row valid bits make cleared rows read as zero.
//
//   channel   signals              handshake
//   --------  -------------------  -----------------------------------
//   request   cmd (req_t)          taken on start & !busy
//   result    result (rsp_t)       one-cycle strobe on done, no backpressure
//
// Each item first reads the cell/fill RAM, then updates the cursor, writes
// back and registers the result in EXEC. done rises in the cycle after
// that, while busy is already low, so items can go back to back. Scroll
// costs nothing extra: the ring pointer advances and the new bottom row's
// valid bit is cleared. Reset clears cursor, ring pointer and row valid
// bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module text_console_cursor_engine #(
    parameter int ROWS    = tcce_pkg::DEF_ROWS,
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  tcce_pkg::req_t cmd,
    output logic          done,
    output tcce_pkg::rsp_t result
);

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int FILL_W = COL_W + 1;
    localparam int SUM_W  = ROW_W + 1;
    localparam int CW     = tcce_pkg::CHAR_W;
    localparam int ROW_FW = tcce_pkg::ROW_FIELD_W;
    localparam int COL_FW = tcce_pkg::COL_FIELD_W;
    localparam int CELL_DEPTH = ROWS * (2 ** COL_W);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                   input logic [ROW_W-1:0] rel);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, rel};
        if (sum >= SUM_W'(ROWS))
        begin
            sum = sum - SUM_W'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    state_t              state_reg, state_next;
    tcce_pkg::req_t      cmd_reg;
    logic [ROW_W-1:0]    rd_phys_reg;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [FILL_W-1:0]   cur_fill_reg, cur_fill_next;
    logic [ROWS-1:0]     row_valid_reg, row_valid_next;
    logic                done_reg;
    tcce_pkg::rsp_t      rsp_reg, rsp_next;

    logic                accept;
    logic                in_range_in;
    logic [ROW_W-1:0]    rd_row_in;
    logic [COL_W-1:0]    rd_col_in;
    logic [ROW_W-1:0]    rd_phys_in;
    logic [ROW_W-1:0]    cur_phys;
    logic                in_range_reg;

    logic                cell_we;
    logic [CW-1:0]       cell_rdata;
    logic                fill_we;
    logic [FILL_W-1:0]   fill_wdata;
    logic [FILL_W-1:0]   fill_rdata;
    logic [FILL_W-1:0]   col_plus;
    logic [CW-1:0]       cell_val;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    // read address straight from the ports so RAM data is ready in EXEC
    assign in_range_in = (int'(cmd.read_row) < ROWS) && (int'(cmd.read_col) < COLUMNS);
    assign rd_row_in   = in_range_in ? ROW_W'(cmd.read_row) : '0;
    assign rd_col_in   = in_range_in ? COL_W'(cmd.read_col) : '0;
    assign rd_phys_in  = phys_row(top_reg, rd_row_in);
    assign cur_phys    = phys_row(top_reg, cur_row_reg);
    assign in_range_reg = (int'(cmd_reg.read_row) < ROWS) && (int'(cmd_reg.read_col) < COLUMNS);

    tcce_ram #(
        .WIDTH (CW),
        .DEPTH (CELL_DEPTH)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr ({cur_phys, cur_col_reg}),
        .wdata (cmd_reg.char_code),
        .raddr ({rd_phys_in, rd_col_in}),
        .rdata (cell_rdata)
    );

    // written-prefix length of each physical row
    tcce_ram #(
        .WIDTH (FILL_W),
        .DEPTH (ROWS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (cur_phys),
        .wdata (fill_wdata),
        .raddr (rd_phys_in),
        .rdata (fill_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_fill_next  = cur_fill_reg;
        row_valid_next = row_valid_reg;
        cell_we        = 1'b0;
        fill_we        = 1'b0;
        fill_wdata     = cur_fill_reg;
        col_plus       = FILL_W'(cur_col_reg) + FILL_W'(1);
        cell_val       = '0;
        rsp_next       = rsp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (cmd_reg.req_type == tcce_pkg::REQ_READ)
                begin
                    if (in_range_reg && row_valid_reg[rd_phys_reg]
                        && (FILL_W'(cmd_reg.read_col) < fill_rdata))
                    begin
                        cell_val = cell_rdata;
                    end
                end
                else
                begin
                    logic adv_row;
                    adv_row = 1'b0;
                    case (cmd_reg.char_code)
                        tcce_pkg::CODE_NUL:
                        begin
                        end
                        tcce_pkg::CODE_CR:
                        begin
                            cur_col_next = '0;
                        end
                        tcce_pkg::CODE_LF:
                        begin
                            adv_row = 1'b1;
                        end
                        default:
                        begin
                            cell_we = 1'b1;
                            fill_we = 1'b1;
                            fill_wdata = (col_plus > cur_fill_reg) ? col_plus : cur_fill_reg;
                            cur_fill_next = fill_wdata;
                            row_valid_next[cur_phys] = 1'b1;
                            if (col_plus >= FILL_W'(COLUMNS))
                            begin
                                adv_row = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = COL_W'(col_plus);
                            end
                        end
                    endcase
                    if (adv_row)
                    begin
                        // a row is always entered at column 0 and is empty then
                        cur_col_next  = '0;
                        cur_fill_next = '0;
                        if (cur_row_reg == ROW_W'(ROWS - 1))
                        begin
                            // old top row becomes the cleared bottom row
                            row_valid_next[top_reg] = 1'b0;
                            top_next = (top_reg == ROW_W'(ROWS - 1)) ? '0
                                                                     : top_reg + ROW_W'(1);
                        end
                        else
                        begin
                            cur_row_next = cur_row_reg + ROW_W'(1);
                        end
                    end
                end
                rsp_next.cell_char  = cell_val;
                rsp_next.cursor_row = ROW_FW'(cur_row_next);
                rsp_next.cursor_col = COL_FW'(cur_col_next);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cur_fill_reg  <= '0;
            row_valid_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            cur_fill_reg  <= cur_fill_next;
            row_valid_reg <= row_valid_next;
            done_reg      <= (state_reg == ST_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd;
            rd_phys_reg <= rd_phys_in;
        end
        rsp_reg <= rsp_next;
    end

`ifndef SYNTH
    // each accepted item raises busy and then finishes with done while busy is low
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 (done && !busy))
        else $error("item did not complete in two cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((int'(result.cursor_row) < ROWS) && (int'(result.cursor_col) < COLUMNS)))
        else $error("cursor out of screen");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(cmd_reg.req_type == tcce_pkg::REQ_PUT)) |-> (result.cell_char == '0))
        else $error("put result carries a cell value");
`endif

endmodule
